[rtl/rc6_pkg.sv]
// shared constants and helper functions for the rc6 block cipher
`timescale 1ns / 1ps
package rc6_pkg;

  // default round count
  localparam int unsigned ROUNDS_DEF = 20;

  // key schedule magic constants
  localparam logic [31:0] RC6_P = 32'hB7E15163;
  localparam logic [31:0] RC6_Q = 32'h9E3779B9;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(1);

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction

  // x * (2x + 1) modulo 2^32
  function automatic logic [31:0] mix_mul(input logic [31:0] x);
    logic [31:0] y;
    y = {x[30:0], 1'b1};
    return x * y;
  endfunction

endpackage

[rtl/rc6_block_cipher.sv]
// top level of the rc6 block cipher: key registers, key schedule, key memory, datapath
`timescale 1ns / 1ps
// rc6 block cipher, 32-bit words, ROUNDS rounds, 128-bit key, one block per request
// key: write key_low (index 0) and key_high (index 1) on the cfg port; every write
//   restarts the key schedule with both registers as they stand
// key schedule: fills the table, then runs each mixing step through KS_RD, KS_A and
//   KS_B over 3*(2*ROUNDS+4) steps; no request is taken meanwhile
// reset: key registers clear and the schedule runs for the all-zero key, so the
//   input side is not ready until the schedule is done
// input request: mode_i (0 encrypt, 1 decrypt) with the block in block_low_i/block_high_i
// output request: result_low_o/result_high_o held in an output register until taken
// sequence: after accept, ST_PRE_RD and ST_PRE_AP, then per round ST_MUL1, ST_MUL2 and
//   ST_RND, as both f() products share one 32x32 multiplier, then ST_POST_RD, ST_POST_AP
// next request: accepted once the previous result has moved into the output register
// stall: a result waiting on out_ready_i holds the datapath in its last step, so a
//   second block waits there until the first is taken
module rc6_block_cipher import rc6_pkg::*; #(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input requests
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  mode_i,
  input  logic [63:0]           block_low_i,
  input  logic [63:0]           block_high_i,
  // output requests
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [63:0]           result_low_o,
  output logic [63:0]           result_high_o
);

  localparam int unsigned NKEYS = 2 * ROUNDS + 4;
  localparam int unsigned AW    = $clog2(NKEYS);
  localparam int unsigned PW    = $clog2(ROUNDS + 2);

  logic [63:0]   key_low_q, key_high_q;
  logic          key_start;
  logic          key_ready;

  // key schedule side of the memory
  logic          ks_we;
  logic [AW-1:0] ks_waddr, ks_raddr;
  logic [31:0]   ks_wdata;

  // datapath side
  logic [PW-1:0] kpair;
  logic [AW-1:0] raddr0, raddr1;
  logic [31:0]   rdata0, rdata1;

  // a write to either key register restarts expansion
  assign key_start = cfg_we_i &&
                     ((cfg_index_i == REG_KEY_LOW) || (cfg_index_i == REG_KEY_HIGH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_KEY_LOW) begin
        key_low_q <= cfg_data_i;
      end else if (cfg_index_i == REG_KEY_HIGH) begin
        key_high_q <= cfg_data_i;
      end
    end
  end

  // port 0 belongs to the schedule until it is done; the pair address
  // picks the even and odd round keys of one round
  assign raddr0 = key_ready ? {kpair, 1'b0} : ks_raddr;
  assign raddr1 = {kpair, 1'b1};

  rc6_ksched #(
    .ROUNDS (ROUNDS)
  ) u_ksched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (key_start),
    .key_low_i   (key_low_q),
    .key_high_i  (key_high_q),
    .key_ready_o (key_ready),
    .we_o        (ks_we),
    .waddr_o     (ks_waddr),
    .wdata_o     (ks_wdata),
    .raddr_o     (ks_raddr),
    .rdata_i     (rdata0)
  );

  rc6_rkey_ram #(
    .DEPTH (NKEYS),
    .AW    (AW)
  ) u_rkey_ram (
    .clk_i    (clk_i),
    .we_i     (ks_we),
    .waddr_i  (ks_waddr),
    .wdata_i  (ks_wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  rc6_core #(
    .ROUNDS (ROUNDS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_ready_i   (key_ready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .block_low_i   (block_low_i),
    .block_high_i  (block_high_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_low_o  (result_low_o),
    .result_high_o (result_high_o),
    .kpair_o       (kpair),
    .key_even_i    (rdata0),
    .key_odd_i     (rdata1)
  );

endmodule

[rtl/rc6_rkey_ram.sv]
// round key memory: one write port, two registered read ports
`timescale 1ns / 1ps
module rc6_rkey_ram #(
  parameter int unsigned DEPTH = 44,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output logic [31:0]   rdata0_o,
  output logic [31:0]   rdata1_o
);

  logic [31:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

[rtl/rc6_ksched.sv]
// key schedule sequencer: table fill followed by the mixing pass
`timescale 1ns / 1ps
module rc6_ksched import rc6_pkg::*; #(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [63:0]                           key_low_i,
  input  logic [63:0]                           key_high_i,
  output logic                                  key_ready_o,
  output logic                                  we_o,
  output logic [$clog2(2*ROUNDS+4)-1:0]         waddr_o,
  output logic [31:0]                           wdata_o,
  output logic [$clog2(2*ROUNDS+4)-1:0]         raddr_o,
  input  logic [31:0]                           rdata_i
);

  localparam int unsigned NKEYS = 2 * ROUNDS + 4;
  localparam int unsigned AW    = $clog2(NKEYS);
  localparam int unsigned STEPS = 3 * NKEYS;
  localparam int unsigned SW    = $clog2(STEPS);

  localparam logic [2:0] KS_INIT = 3'd0;
  localparam logic [2:0] KS_RD   = 3'd1;
  localparam logic [2:0] KS_A    = 3'd2;
  localparam logic [2:0] KS_B    = 3'd3;
  localparam logic [2:0] KS_DONE = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] i_q, i_d;
  logic [1:0]    j_q, j_d;
  logic [SW-1:0] step_q, step_d;
  logic [31:0]   acc_q, acc_d;
  logic [31:0]   a_q, b_q;
  logic [31:0]   lw_q [4];

  logic [31:0] a_new, ab_sum, b_sum, b_new;
  logic [AW-1:0] i_next;

  assign a_new  = rotl32(rdata_i + a_q + b_q, 5'd3);
  assign ab_sum = a_q + b_q;
  assign b_sum  = lw_q[j_q] + ab_sum;
  assign b_new  = rotl32(b_sum, ab_sum[4:0]);
  assign i_next = (i_q == AW'(NKEYS - 1)) ? '0 : i_q + AW'(1);

  assign key_ready_o = (state_q == KS_DONE);
  assign raddr_o     = i_q;
  assign waddr_o     = i_q;
  assign we_o        = (state_q == KS_INIT) || (state_q == KS_A);
  assign wdata_o     = (state_q == KS_INIT) ? acc_q : a_new;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    step_d  = step_q;
    acc_d   = acc_q;
    case (state_q)
      KS_INIT: begin
        acc_d = acc_q + RC6_Q;
        i_d   = i_next;
        if (i_q == AW'(NKEYS - 1)) begin
          j_d     = '0;
          step_d  = '0;
          state_d = KS_RD;
        end
      end
      KS_RD: state_d = KS_A;
      KS_A:  state_d = KS_B;
      KS_B: begin
        i_d = i_next;
        j_d = j_q + 2'd1;
        if (step_q == SW'(STEPS - 1)) begin
          state_d = KS_DONE;
        end else begin
          step_d  = step_q + SW'(1);
          state_d = KS_RD;
        end
      end
      KS_DONE: state_d = KS_DONE;
      default: state_d = KS_INIT;
    endcase
    if (start_i) begin
      state_d = KS_INIT;
      i_d     = '0;
      j_d     = '0;
      step_d  = '0;
      acc_d   = RC6_P;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KS_INIT;
      i_q     <= '0;
      j_q     <= '0;
      step_q  <= '0;
      acc_q   <= RC6_P;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      step_q  <= step_d;
      acc_q   <= acc_d;
    end
  end

  // mixing registers, loaded during the fill
  always_ff @(posedge clk_i) begin
    case (state_q)
      KS_INIT: begin
        a_q      <= '0;
        b_q      <= '0;
        lw_q[0]  <= key_low_i[31:0];
        lw_q[1]  <= key_low_i[63:32];
        lw_q[2]  <= key_high_i[31:0];
        lw_q[3]  <= key_high_i[63:32];
      end
      KS_A: a_q <= a_new;
      KS_B: begin
        b_q       <= b_new;
        lw_q[j_q] <= b_new;
      end
      default: ;
    endcase
  end

endmodule

[rtl/rc6_core.sv]
// block datapath: one shared multiplier and round logic under a sequencer
`timescale 1ns / 1ps
module rc6_core import rc6_pkg::*; #(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          key_ready_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [63:0]                   block_low_i,
  input  logic [63:0]                   block_high_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [63:0]                   result_low_o,
  output logic [63:0]                   result_high_o,
  output logic [$clog2(ROUNDS+2)-1:0]   kpair_o,
  input  logic [31:0]                   key_even_i,
  input  logic [31:0]                   key_odd_i
);

  localparam int unsigned PW = $clog2(ROUNDS + 2);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PRE_RD  = 3'd1;
  localparam logic [2:0] ST_PRE_AP  = 3'd2;
  localparam logic [2:0] ST_MUL1    = 3'd3;
  localparam logic [2:0] ST_MUL2    = 3'd4;
  localparam logic [2:0] ST_RND     = 3'd5;
  localparam logic [2:0] ST_POST_RD = 3'd6;
  localparam logic [2:0] ST_POST_AP = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [PW-1:0] kp_q, kp_d;
  logic          out_valid_q, out_valid_d;
  logic          mode_q;
  logic [31:0]   wa_q, wb_q, wc_q, wd_q;
  logic [31:0]   p_q, t_q;
  logic [63:0]   res_low_q, res_high_q;

  logic          accept, load, last_round;
  logic [PW-1:0] kp_step;
  logic [31:0]   mul_in, mul_out, u_val;
  logic [31:0]   enc_a, enc_c, dec_a, dec_c;

  assign in_ready_o    = (state_q == ST_IDLE) && key_ready_i;
  assign accept        = in_valid_i && in_ready_o;
  assign load          = (state_q == ST_POST_AP) && (!out_valid_q || out_ready_i);
  assign kp_step       = mode_q ? kp_q - PW'(1) : kp_q + PW'(1);
  assign last_round    = mode_q ? (kp_q == PW'(1)) : (kp_q == PW'(ROUNDS));
  assign kpair_o       = kp_q;
  assign out_valid_o   = out_valid_q;
  assign result_low_o  = res_low_q;
  assign result_high_o = res_high_q;

  // shared multiplier: f(b) in the first pass, f(d) in the second; decrypt uses wa_q, then wc_q
  always_comb begin
    if (state_q == ST_MUL1) begin
      mul_in = mode_q ? wa_q : wb_q;
    end else begin
      mul_in = mode_q ? wc_q : wd_q;
    end
  end
  assign mul_out = mix_mul(mul_in);
  assign u_val   = rotl32(p_q, 5'd5);

  assign enc_a = rotl32(wa_q ^ t_q, u_val[4:0]) + key_even_i;
  assign enc_c = rotl32(wc_q ^ u_val, t_q[4:0]) + key_odd_i;
  assign dec_a = rotr32(wd_q - key_even_i, u_val[4:0]) ^ t_q;
  assign dec_c = rotr32(wb_q - key_odd_i, t_q[4:0]) ^ u_val;

  always_comb begin
    state_d = state_q;
    kp_d    = kp_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_PRE_RD;
          kp_d    = mode_i ? PW'(ROUNDS + 1) : '0;
        end
      end
      ST_PRE_RD: state_d = ST_PRE_AP;
      ST_PRE_AP: begin
        kp_d    = kp_step;
        state_d = ST_MUL1;
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_RND;
      ST_RND: begin
        kp_d    = kp_step;
        state_d = last_round ? ST_POST_RD : ST_MUL1;
      end
      ST_POST_RD: state_d = ST_POST_AP;
      ST_POST_AP: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kp_q        <= kp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_q <= mode_i;
          wa_q   <= block_low_i[31:0];
          wb_q   <= block_low_i[63:32];
          wc_q   <= block_high_i[31:0];
          wd_q   <= block_high_i[63:32];
        end
      end
      ST_PRE_AP: begin
        if (mode_q) begin
          wa_q <= wa_q - key_even_i;
          wc_q <= wc_q - key_odd_i;
        end else begin
          wb_q <= wb_q + key_even_i;
          wd_q <= wd_q + key_odd_i;
        end
      end
      ST_MUL1: p_q <= mul_out;
      ST_MUL2: begin
        t_q <= rotl32(p_q, 5'd5);
        p_q <= mul_out;
      end
      ST_RND: begin
        if (mode_q) begin
          wa_q <= dec_a;
          wb_q <= wa_q;
          wc_q <= dec_c;
          wd_q <= wc_q;
        end else begin
          wa_q <= wb_q;
          wb_q <= enc_c;
          wc_q <= wd_q;
          wd_q <= enc_a;
        end
      end
      ST_POST_AP: begin
        if (load) begin
          if (mode_q) begin
            res_low_q  <= {wb_q - key_even_i, wa_q};
            res_high_q <= {wd_q - key_odd_i, wc_q};
          end else begin
            res_low_q  <= {wb_q, wa_q + key_even_i};
            res_high_q <= {wd_q, wc_q + key_odd_i};
          end
        end
      end
      default: ;
    endcase
  end

endmodule
